@@ rtl/mtcv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the MIDI to control-voltage converter.
// No dependencies; used by every module under rtl/.
package mtcv_pkg;

  // Configuration register reset values
  localparam logic [7:0] TRIG_LEN_RESET   = 8'd10;
  localparam logic [6:0] SUS_THRESH_RESET = 7'd64;

  // Result queue depth in entries
  localparam int unsigned OUT_DEPTH_DEFAULT = 4;

  // Register indexes on the configuration port
  localparam logic REG_TRIG_LEN   = 1'b0;
  localparam logic REG_SUS_THRESH = 1'b1;

  // Status kinds (high nibble of a status byte)
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CONTROL  = 4'hB;
  localparam logic [3:0] ST_PROGRAM  = 4'hC;
  localparam logic [3:0] ST_BEND     = 4'hE;
  localparam logic [3:0] ST_SYSTEM   = 4'hF;

  // Controller numbers with special handling
  localparam logic [6:0] CC_MODULATION = 7'd1;
  localparam logic [6:0] CC_PAN        = 7'd10;
  localparam logic [6:0] CC_SUSTAIN    = 7'd64;

  // Byte position within a channel message
  localparam logic [1:0] POS_IDLE   = 2'd0;
  localparam logic [1:0] POS_FIRST  = 2'd1;
  localparam logic [1:0] POS_SECOND = 2'd2;

  // Input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    EV_TRIG_END   = 3'd0,
    EV_NOTE_ON    = 3'd1,
    EV_NOTE_OFF   = 3'd2,
    EV_PROGRAM    = 3'd3,
    EV_CONTROLLER = 3'd4,
    EV_BEND       = 3'd5,
    EV_SYSTEM     = 3'd6
  } event_kind_e;

  typedef enum logic [1:0] {
    DAC_NONE  = 2'd0,
    DAC_WIDE  = 2'd1,
    DAC_NARROW = 2'd2
  } dac_target_e;

  typedef struct packed {
    logic       command;
    logic [7:0] midi_byte;
  } in_item_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [4:0]  midi_channel;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    dac_target_e dac_target;
    logic [1:0]  dac_channel;
    logic [15:0] dac_value;
    logic        gate_level;
    logic        trigger_level;
    logic        sustain_level;
    logic        last_of_run;
  } out_item_t;

  // Results produced by one accepted transaction
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } res_push_t;

endpackage

@@ rtl/midi_to_control_voltage.sv @@
`timescale 1ns / 1ps
// MIDI to control-voltage converter top level.
// Results are registered in the result queue and are visible in the cycle after the input transaction is accepted.
// Throughput: one input per cycle while the result queue has room for two results;
// a note on yields two results.
// Reset: asynchronous active low; clears parser state and queue, config to defaults.
// Depends on mtcv_pkg, mtcv_cfg, mtcv_parser, mtcv_outq.
module midi_to_control_voltage #(
  parameter int unsigned OutDepth = mtcv_pkg::OUT_DEPTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mtcv_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mtcv_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0]          trig_len;
  logic [6:0]          sus_thresh;
  logic                accept;
  mtcv_pkg::res_push_t push;

  assign accept = in_valid_i & in_ready_o;

  mtcv_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .trig_len_o   (trig_len),
    .sus_thresh_o (sus_thresh)
  );

  mtcv_parser u_parser (
    .rst_ni       (rst_ni),
    .clk_i        (clk_i),
    .accept_i     (accept),
    .item_i       (in_data_i),
    .trig_len_i   (trig_len),
    .sus_thresh_i (sus_thresh),
    .push_o       (push)
  );

  mtcv_outq #(
    .Depth (OutDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/mtcv_cfg.sv @@
`timescale 1ns / 1ps
// APB-style configuration registers: trigger length and sustain threshold.
// Depends on mtcv_pkg.
module mtcv_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  trig_len_o,
  output logic [6:0]  sus_thresh_o
);

  logic [7:0] trig_len_q;
  logic [6:0] sus_thresh_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_len_q   <= mtcv_pkg::TRIG_LEN_RESET;
      sus_thresh_q <= mtcv_pkg::SUS_THRESH_RESET;
    end else if (wr_en) begin
      if (paddr[2] == mtcv_pkg::REG_TRIG_LEN) begin
        trig_len_q <= pwdata[7:0];
      end else begin
        sus_thresh_q <= pwdata[6:0];
      end
    end
  end

  // Read mux
  always_comb begin
    if (paddr[2] == mtcv_pkg::REG_SUS_THRESH) begin
      prdata = {25'd0, sus_thresh_q};
    end else begin
      prdata = {24'd0, trig_len_q};
    end
  end

  assign trig_len_o   = trig_len_q;
  assign sus_thresh_o = sus_thresh_q;

endmodule

@@ rtl/mtcv_parser.sv @@
`timescale 1ns / 1ps
// MIDI message parser with running status, gate/trigger/sustain state and
// trigger countdown; emits up to two results per transaction. Depends on mtcv_pkg.
module mtcv_parser (
  input  logic                rst_ni,
  input  logic                clk_i,
  input  logic                accept_i,
  input  mtcv_pkg::in_item_t  item_i,
  input  logic [7:0]          trig_len_i,
  input  logic [6:0]          sus_thresh_i,
  output mtcv_pkg::res_push_t push_o
);

  logic [3:0] status_q, status_d;
  logic [3:0] chan_q, chan_d;
  logic [1:0] pos_q, pos_d;
  logic [6:0] held_q, held_d;
  logic       gate_q, gate_d;
  logic       trig_q, trig_d;
  logic       sus_q, sus_d;
  logic [7:0] cd_q, cd_d;

  logic [4:0] chan_num;
  logic [6:0] b7;
  logic [6:0] d1;
  mtcv_pkg::out_item_t r0, r1;
  logic [1:0] cnt;

  assign chan_num = {1'b0, chan_q} + 5'd1;
  assign b7       = item_i.midi_byte[6:0];
  assign d1       = held_q;

  // Next state and results for one transaction
  always_comb begin
    status_d = status_q;
    chan_d   = chan_q;
    pos_d    = pos_q;
    held_d   = held_q;
    gate_d   = gate_q;
    trig_d   = trig_q;
    sus_d    = sus_q;
    cd_d     = cd_q;
    cnt      = 2'd0;
    r0       = '0;

    if (item_i.command == mtcv_pkg::CMD_TICK) begin
      // Millisecond tick: run the trigger countdown
      if (trig_q) begin
        if (cd_q <= 8'd1) begin
          cd_d   = 8'd0;
          trig_d = 1'b0;
          cnt    = 2'd1;
          r0.event_kind = mtcv_pkg::EV_TRIG_END;
        end else begin
          cd_d = cd_q - 8'd1;
        end
      end
    end else if (item_i.midi_byte[7]) begin
      // Status byte
      status_d = item_i.midi_byte[7:4];
      chan_d   = item_i.midi_byte[3:0];
      if (item_i.midi_byte[7:4] == mtcv_pkg::ST_SYSTEM) begin
        pos_d = mtcv_pkg::POS_IDLE;
        cnt   = 2'd1;
        r0.event_kind = mtcv_pkg::EV_SYSTEM;
        r0.data_first = {3'd0, item_i.midi_byte[3:0]};
      end else begin
        pos_d = mtcv_pkg::POS_FIRST;
      end
    end else if (pos_q == mtcv_pkg::POS_FIRST) begin
      // First data byte
      if (status_q inside {mtcv_pkg::ST_NOTE_ON, mtcv_pkg::ST_NOTE_OFF,
                           mtcv_pkg::ST_CONTROL, mtcv_pkg::ST_BEND}) begin
        held_d = b7;
        pos_d  = mtcv_pkg::POS_SECOND;
      end else if (status_q == mtcv_pkg::ST_PROGRAM) begin
        cnt = 2'd1;
        r0.event_kind   = mtcv_pkg::EV_PROGRAM;
        r0.midi_channel = chan_num;
        r0.data_first   = b7;
      end
    end else if (pos_q == mtcv_pkg::POS_SECOND) begin
      // Second data byte completes the message
      pos_d = mtcv_pkg::POS_FIRST;
      r0.midi_channel = chan_num;
      r0.data_first   = d1;
      r0.data_second  = b7;
      if (status_q == mtcv_pkg::ST_NOTE_OFF ||
          (status_q == mtcv_pkg::ST_NOTE_ON && b7 == 7'd0)) begin
        gate_d = 1'b0;
        cnt    = 2'd1;
        r0.event_kind = mtcv_pkg::EV_NOTE_OFF;
      end else if (status_q == mtcv_pkg::ST_NOTE_ON) begin
        gate_d = 1'b1;
        trig_d = 1'b1;
        cd_d   = trig_len_i;
        cnt    = 2'd2;
        r0.event_kind = mtcv_pkg::EV_NOTE_ON;
        r0.dac_target = mtcv_pkg::DAC_WIDE;
        r0.dac_value  = {d1, 9'd0};
      end else if (status_q == mtcv_pkg::ST_CONTROL) begin
        cnt = 2'd1;
        r0.event_kind = mtcv_pkg::EV_CONTROLLER;
        if (d1 == mtcv_pkg::CC_MODULATION) begin
          r0.dac_target = mtcv_pkg::DAC_NARROW;
          r0.dac_value  = {8'd0, b7, 1'b0};
        end else if (d1 == mtcv_pkg::CC_PAN) begin
          r0.dac_target  = mtcv_pkg::DAC_NARROW;
          r0.dac_channel = 2'd1;
          r0.dac_value   = {8'd0, b7, 1'b0};
        end else if (d1 == mtcv_pkg::CC_SUSTAIN) begin
          sus_d = (b7 >= sus_thresh_i);
        end
      end else if (status_q == mtcv_pkg::ST_BEND) begin
        cnt = 2'd1;
        r0.event_kind  = mtcv_pkg::EV_BEND;
        r0.dac_target  = mtcv_pkg::DAC_WIDE;
        r0.dac_channel = 2'd2;
        r0.dac_value   = {b7, d1, 2'b00};
      end
    end

    // Levels after this step
    r0.gate_level    = gate_d;
    r0.trigger_level = trig_d;
    r0.sustain_level = sus_d;
    r0.last_of_run   = (cnt == 2'd1);

    // Second result of a note on: velocity write
    r1             = r0;
    r1.dac_channel = 2'd1;
    r1.dac_value   = {b7, 9'd0};
    r1.last_of_run = 1'b1;
  end

  assign push_o.count  = accept_i ? cnt : 2'd0;
  assign push_o.first  = r0;
  assign push_o.second = r1;

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= 4'd0;
      chan_q   <= 4'd0;
      pos_q    <= mtcv_pkg::POS_IDLE;
      held_q   <= 7'd0;
      gate_q   <= 1'b0;
      trig_q   <= 1'b0;
      sus_q    <= 1'b0;
      cd_q     <= 8'd0;
    end else if (accept_i) begin
      status_q <= status_d;
      chan_q   <= chan_d;
      pos_q    <= pos_d;
      held_q   <= held_d;
      gate_q   <= gate_d;
      trig_q   <= trig_d;
      sus_q    <= sus_d;
      cd_q     <= cd_d;
    end
  end

endmodule

@@ rtl/mtcv_outq.sv @@
`timescale 1ns / 1ps
// Result queue: takes zero, one or two results per cycle, hands out one while out_ready_i is high.
// Depends on mtcv_pkg.
module mtcv_outq #(
  parameter int unsigned Depth = mtcv_pkg::OUT_DEPTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mtcv_pkg::res_push_t push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mtcv_pkg::out_item_t out_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  mtcv_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q, wr_nx;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  // room for a full pair of results
  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign wr_nx       = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_nx] <= push_i.second;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.count == 2'd1) begin
        wr_q <= wr_nx;
      end else if (push_i.count == 2'd2) begin
        wr_q <= (wr_nx == PtrW'(Depth - 1)) ? '0 : wr_nx + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i.count) - CntW'(pop);
    end
  end

endmodule
